// ===== sv/zafa_pkg.sv =====
// ----------------------------------------------------------------------------
// zafa_pkg
// Shared types and codes of the Z80 accumulator and flag ALU: the request
// and response words, the operation codes and the flag bit positions.
// ----------------------------------------------------------------------------
package zafa_pkg;

   // operation codes
   localparam logic [3:0] OP_RLCA  = 4'd0;
   localparam logic [3:0] OP_RRCA  = 4'd1;
   localparam logic [3:0] OP_RLA   = 4'd2;
   localparam logic [3:0] OP_RRA   = 4'd3;
   localparam logic [3:0] OP_DAA   = 4'd4;
   localparam logic [3:0] OP_CPL   = 4'd5;
   localparam logic [3:0] OP_SCF   = 4'd6;
   localparam logic [3:0] OP_CCF   = 4'd7;
   localparam logic [3:0] OP_INC8  = 4'd8;
   localparam logic [3:0] OP_DEC8  = 4'd9;
   localparam logic [3:0] OP_ADD16 = 4'd10;
   localparam logic [3:0] OP_INC16 = 4'd11;
   localparam logic [3:0] OP_DEC16 = 4'd12;

   // flag byte bit positions: S Z 5 H 3 PV N C
   localparam int unsigned FLAG_S  = 7;
   localparam int unsigned FLAG_Z  = 6;
   localparam int unsigned FLAG_Y  = 5;
   localparam int unsigned FLAG_H  = 4;
   localparam int unsigned FLAG_X  = 3;
   localparam int unsigned FLAG_PV = 2;
   localparam int unsigned FLAG_N  = 1;
   localparam int unsigned FLAG_C  = 0;

   // request word
   typedef struct packed {
      logic [3:0]  opcode;
      logic [7:0]  operand_byte;
      logic [7:0]  flags_in;
      logic [15:0] word_left;
      logic [15:0] word_right;
   } req_type;

   // response word
   typedef struct packed {
      logic [7:0]  byte_result;
      logic [15:0] word_result;
      logic [7:0]  flags_out;
   } rsp_type;

endpackage

// ===== sv/z80_accumulator_flag_alu_top.sv =====
// ----------------------------------------------------------------------------
// z80_accumulator_flag_alu_top
// Z80 accumulator and flag ALU: rotates, DAA, CPL, SCF, CCF, 8-bit INC/DEC,
// ADD HL,rp and 16-bit INC/DEC, one operation per word.
// ----------------------------------------------------------------------------
// A word is taken on every clock where start is high; busy is always low, so
// one operation per cycle is sustained. Each word gives exactly one response
// through the input register, then the result register, shown for one
// cycle with rsp_valid high. The receiver cannot stall the block and must
// take every response in the cycle it appears. Flag bits an operation does
// not touch, including bits 5 and 3, are copied from flags_in; codes 13 to 15
// pass the operand, word_left and the flags through unchanged.
module z80_accumulator_flag_alu_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  zafa_pkg::req_type req_word,
   output logic              rsp_valid,
   output zafa_pkg::rsp_type rsp_word
);

   logic              valid_ff;
   logic              valid_in;
   zafa_pkg::req_type req_ff;
   zafa_pkg::req_type req_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   zafa_pkg::rsp_type rsp_ff;
   zafa_pkg::rsp_type rsp_in;

   logic [7:0]  byte_res;
   logic [7:0]  byte_flags;
   logic [15:0] word_res;
   logic [7:0]  word_flags;

   // never stalls
   assign busy = 1'b0;

   // input register
   assign valid_in = start & ~busy;
   assign req_in   = (start & ~busy) ? req_word : req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      req_ff <= req_in;
   end

   // datapath
   zafa_byte_unit u_byte (
      .opcode       (req_ff.opcode),
      .operand_byte (req_ff.operand_byte),
      .flags_in     (req_ff.flags_in),
      .byte_result  (byte_res),
      .flags_out    (byte_flags)
   );

   zafa_word_unit u_word (
      .opcode      (req_ff.opcode),
      .flags_in    (req_ff.flags_in),
      .word_left   (req_ff.word_left),
      .word_right  (req_ff.word_right),
      .word_result (word_res),
      .flags_out   (word_flags)
   );

   // merge the two halves; only ADD16 changes flags on the word side
   always_comb begin
      rsp_in.byte_result = byte_res;
      rsp_in.word_result = word_res;
      rsp_in.flags_out   = (req_ff.opcode == zafa_pkg::OP_ADD16) ? word_flags : byte_flags;
   end
   assign rsp_valid_in = valid_ff;

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // every captured word reaches the result register next cycle
   assert property (@(posedge clock) disable iff (reset)
      valid_ff |=> rsp_valid_ff)
      else $error("captured word did not produce a response");

   assert property (@(posedge clock) disable iff (reset)
      !valid_ff |=> !rsp_valid_ff)
      else $error("response strobe without a captured word");

   // 16-bit steps leave the flags alone
   assert property (@(posedge clock) disable iff (reset)
      valid_ff && (req_ff.opcode == zafa_pkg::OP_INC16 ||
                   req_ff.opcode == zafa_pkg::OP_DEC16)
      |=> rsp_ff.flags_out == $past(req_ff.flags_in))
      else $error("16-bit step changed the flags");

   // 8-bit ops leave the word untouched
   assert property (@(posedge clock) disable iff (reset)
      valid_ff && (req_ff.opcode < zafa_pkg::OP_ADD16)
      |=> rsp_ff.word_result == $past(req_ff.word_left))
      else $error("8-bit operation changed the word result");

endmodule

// ===== sv/zafa_byte_unit.sv =====
// ----------------------------------------------------------------------------
// zafa_byte_unit
// 8-bit side of the ALU: rotates, DAA, CPL, SCF, CCF, INC8 and DEC8 with
// their flags. Other codes pass the operand and flags through.
// ----------------------------------------------------------------------------
module zafa_byte_unit (
   input  logic [3:0] opcode,
   input  logic [7:0] operand_byte,
   input  logic [7:0] flags_in,
   output logic [7:0] byte_result,
   output logic [7:0] flags_out
);

   logic [7:0] a;
   logic [7:0] f;
   logic       oc;
   logic [7:0] rot_keep;
   logic [3:0] lo;
   logic       lo_gt9;
   logic       hi_gt99;
   logic [7:0] diff;
   logic       daa_c;
   logic       daa_h;
   logic [7:0] daa_b;
   logic [7:0] inc_b;
   logic [7:0] dec_b;

   assign a        = operand_byte;
   assign f        = flags_in;
   assign oc       = f[zafa_pkg::FLAG_C];
   // flags with H, N and C cleared
   assign rot_keep = {f[7:5], 1'b0, f[3:2], 2'b00};

   // decimal adjust correction
   assign lo      = a[3:0];
   assign lo_gt9  = (lo > 4'd9);
   assign hi_gt99 = (a > 8'h99);
   assign diff    = {1'b0, (hi_gt99 | oc), (hi_gt99 | oc), 1'b0,
                     1'b0, (lo_gt9 | f[zafa_pkg::FLAG_H]),
                     (lo_gt9 | f[zafa_pkg::FLAG_H]), 1'b0};
   assign daa_c   = oc | hi_gt99;
   assign daa_b   = f[zafa_pkg::FLAG_N] ? (a - diff) : (a + diff);
   assign daa_h   = f[zafa_pkg::FLAG_N] ? (f[zafa_pkg::FLAG_H] & (lo < 4'd6)) : lo_gt9;

   assign inc_b = a + 8'd1;
   assign dec_b = a - 8'd1;

   // operation select
   always_comb begin
      byte_result = a;
      flags_out   = f;
      case (opcode)
         zafa_pkg::OP_RLCA: begin
            byte_result = {a[6:0], a[7]};
            flags_out   = rot_keep | {7'd0, a[7]};
         end
         zafa_pkg::OP_RRCA: begin
            byte_result = {a[0], a[7:1]};
            flags_out   = rot_keep | {7'd0, a[0]};
         end
         zafa_pkg::OP_RLA: begin
            byte_result = {a[6:0], oc};
            flags_out   = rot_keep | {7'd0, a[7]};
         end
         zafa_pkg::OP_RRA: begin
            byte_result = {oc, a[7:1]};
            flags_out   = rot_keep | {7'd0, a[0]};
         end
         zafa_pkg::OP_DAA: begin
            byte_result = daa_b;
            flags_out   = {daa_b[7], (daa_b == 8'd0), f[5], daa_h, f[3],
                           ~(^daa_b), f[1], daa_c};
         end
         zafa_pkg::OP_CPL: begin
            byte_result = ~a;
            flags_out   = f | 8'h12;
         end
         zafa_pkg::OP_SCF: begin
            flags_out = rot_keep | 8'h01;
         end
         zafa_pkg::OP_CCF: begin
            flags_out = rot_keep | {3'd0, oc, 3'd0, ~oc};
         end
         zafa_pkg::OP_INC8: begin
            byte_result = inc_b;
            flags_out   = {inc_b[7], (inc_b == 8'd0), f[5], (lo == 4'hF), f[3],
                           (a == 8'h7F), 1'b0, oc};
         end
         zafa_pkg::OP_DEC8: begin
            byte_result = dec_b;
            flags_out   = {dec_b[7], (dec_b == 8'd0), f[5], (lo == 4'h0), f[3],
                           (a == 8'h80), 1'b1, oc};
         end
         default: begin
            byte_result = a;
            flags_out   = f;
         end
      endcase
   end

endmodule

// ===== sv/zafa_word_unit.sv =====
// ----------------------------------------------------------------------------
// zafa_word_unit
// 16-bit side of the ALU: ADD HL,rp with H, N and C, and the 16-bit
// increment and decrement. Other codes pass word_left and flags through.
// ----------------------------------------------------------------------------
module zafa_word_unit (
   input  logic [3:0]  opcode,
   input  logic [7:0]  flags_in,
   input  logic [15:0] word_left,
   input  logic [15:0] word_right,
   output logic [15:0] word_result,
   output logic [7:0]  flags_out
);

   logic [16:0] sum;
   logic [12:0] half;

   // full sum and the carry out of bit 11
   assign sum  = {1'b0, word_left} + {1'b0, word_right};
   assign half = {1'b0, word_left[11:0]} + {1'b0, word_right[11:0]};

   always_comb begin
      word_result = word_left;
      flags_out   = flags_in;
      case (opcode)
         zafa_pkg::OP_ADD16: begin
            word_result = sum[15:0];
            flags_out   = {flags_in[7:5], half[12], flags_in[3:2], 1'b0, sum[16]};
         end
         zafa_pkg::OP_INC16: begin
            word_result = word_left + 16'd1;
         end
         zafa_pkg::OP_DEC16: begin
            word_result = word_left - 16'd1;
         end
         default: begin
            word_result = word_left;
            flags_out   = flags_in;
         end
      endcase
   end

endmodule

// ===== verif/zafa_alu_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zafa_alu_checker
// Watches the request and response channels of the accumulator and flag ALU.
// Each accepted request word is run through an independent model of the
// Z80 flag rules, and the expected response is queued. Every response strobe
// is compared field by field against the oldest queued response. The number
// of failures and the count of responses still owed go back to the bench top.
// ----------------------------------------------------------------------------
module zafa_alu_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  zafa_pkg::req_type req_word,
   input  logic              rsp_valid,
   input  zafa_pkg::rsp_type rsp_word,
   output int                fail_count,
   output int                pending_count
);

   zafa_pkg::rsp_type owed_results[$];

   // flag rules of the unprefixed accumulator and 16-bit operations
   function automatic zafa_pkg::rsp_type compute_alu_result(input zafa_pkg::req_type w);
      logic [7:0]        a;
      logic [7:0]        f;
      logic [7:0]        nf;
      logic [7:0]        keep;
      logic [7:0]        b;
      logic [7:0]        diff;
      logic [15:0]       wres;
      logic [16:0]       sum;
      logic [12:0]       half;
      logic              carry;
      zafa_pkg::rsp_type res;
      a    = w.operand_byte;
      f    = w.flags_in;
      nf   = f;
      b    = a;
      wres = w.word_left;
      // rotates, scf, ccf and add16 clear n and rewrite h and c
      keep = f;
      keep[zafa_pkg::FLAG_H] = 1'b0;
      keep[zafa_pkg::FLAG_N] = 1'b0;
      keep[zafa_pkg::FLAG_C] = 1'b0;
      case (w.opcode)
         zafa_pkg::OP_RLCA: begin
            b  = {a[6:0], a[7]};
            nf = keep;
            nf[zafa_pkg::FLAG_C] = a[7];
         end
         zafa_pkg::OP_RRCA: begin
            b  = {a[0], a[7:1]};
            nf = keep;
            nf[zafa_pkg::FLAG_C] = a[0];
         end
         zafa_pkg::OP_RLA: begin
            b  = {a[6:0], f[zafa_pkg::FLAG_C]};
            nf = keep;
            nf[zafa_pkg::FLAG_C] = a[7];
         end
         zafa_pkg::OP_RRA: begin
            b  = {f[zafa_pkg::FLAG_C], a[7:1]};
            nf = keep;
            nf[zafa_pkg::FLAG_C] = a[0];
         end
         zafa_pkg::OP_DAA: begin
            // low correction on nibble above nine or h, high on a above 99 or c
            diff  = 8'h00;
            carry = f[zafa_pkg::FLAG_C];
            if (a[3:0] > 4'd9 || f[zafa_pkg::FLAG_H]) diff = diff | 8'h06;
            if (a > 8'h99 || f[zafa_pkg::FLAG_C]) begin
               diff  = diff | 8'h60;
               carry = 1'b1;
            end
            b = f[zafa_pkg::FLAG_N] ? (a - diff) : (a + diff);
            nf[zafa_pkg::FLAG_S]  = b[7];
            nf[zafa_pkg::FLAG_Z]  = (b == 8'h00);
            nf[zafa_pkg::FLAG_H]  = f[zafa_pkg::FLAG_N] ?
                                    (f[zafa_pkg::FLAG_H] && a[3:0] < 4'd6) :
                                    (a[3:0] > 4'd9);
            nf[zafa_pkg::FLAG_PV] = ~^b;
            nf[zafa_pkg::FLAG_C]  = carry;
         end
         zafa_pkg::OP_CPL: begin
            b = ~a;
            nf[zafa_pkg::FLAG_H] = 1'b1;
            nf[zafa_pkg::FLAG_N] = 1'b1;
         end
         zafa_pkg::OP_SCF: begin
            nf = keep;
            nf[zafa_pkg::FLAG_C] = 1'b1;
         end
         zafa_pkg::OP_CCF: begin
            nf = keep;
            nf[zafa_pkg::FLAG_H] = f[zafa_pkg::FLAG_C];
            nf[zafa_pkg::FLAG_C] = ~f[zafa_pkg::FLAG_C];
         end
         zafa_pkg::OP_INC8: begin
            b = a + 8'd1;
            nf[zafa_pkg::FLAG_S]  = b[7];
            nf[zafa_pkg::FLAG_Z]  = (b == 8'h00);
            nf[zafa_pkg::FLAG_H]  = (a[3:0] == 4'hF);
            nf[zafa_pkg::FLAG_PV] = (a == 8'h7F);
            nf[zafa_pkg::FLAG_N]  = 1'b0;
         end
         zafa_pkg::OP_DEC8: begin
            b = a - 8'd1;
            nf[zafa_pkg::FLAG_S]  = b[7];
            nf[zafa_pkg::FLAG_Z]  = (b == 8'h00);
            nf[zafa_pkg::FLAG_H]  = (a[3:0] == 4'h0);
            nf[zafa_pkg::FLAG_PV] = (a == 8'h80);
            nf[zafa_pkg::FLAG_N]  = 1'b1;
         end
         zafa_pkg::OP_ADD16: begin
            sum  = {1'b0, w.word_left} + {1'b0, w.word_right};
            half = {1'b0, w.word_left[11:0]} + {1'b0, w.word_right[11:0]};
            wres = sum[15:0];
            nf   = keep;
            nf[zafa_pkg::FLAG_H] = half[12];
            nf[zafa_pkg::FLAG_C] = sum[16];
         end
         zafa_pkg::OP_INC16: wres = w.word_left + 16'd1;
         zafa_pkg::OP_DEC16: wres = w.word_left - 16'd1;
         default: begin
            // unused codes pass everything through
         end
      endcase
      res.byte_result = b;
      res.word_result = wres;
      res.flags_out   = nf;
      return res;
   endfunction

   // compare each response strobe, then queue the prediction for a new word
   always @(posedge clock) begin
      zafa_pkg::rsp_type exp_rsp;
      if (reset) begin
         owed_results.delete();
         fail_count    <= 0;
         pending_count <= 0;
      end else begin
         if (rsp_valid) begin
            if (owed_results.size() == 0) begin
               $display("%0t: response with none expected: byte %h word %h flags %h",
                        $time, rsp_word.byte_result, rsp_word.word_result,
                        rsp_word.flags_out);
               fail_count <= fail_count + 1;
            end else begin
               exp_rsp = owed_results.pop_front();
               if (rsp_word.byte_result !== exp_rsp.byte_result ||
                   rsp_word.word_result !== exp_rsp.word_result ||
                   rsp_word.flags_out   !== exp_rsp.flags_out) begin
                  $display({"%0t: mismatch expected byte %h word %h flags %h, ",
                            "got byte %h word %h flags %h"},
                           $time, exp_rsp.byte_result, exp_rsp.word_result,
                           exp_rsp.flags_out, rsp_word.byte_result,
                           rsp_word.word_result, rsp_word.flags_out);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (start && !busy) owed_results.push_back(compute_alu_result(req_word));
         pending_count <= owed_results.size();
      end
   end

endmodule

// ===== verif/z80_accumulator_flag_alu_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// z80_accumulator_flag_alu_top_tb
// Drives the accumulator and flag ALU with a directed set of corner words
// (every operation, DAA correction cases, INC/DEC overflow, 16-bit carries
// and wraps, unused codes) and then random words in phases with and without
// sender gaps. A checker beside the block predicts and compares responses.
// ----------------------------------------------------------------------------
module z80_accumulator_flag_alu_top_tb;

   localparam int          RANDOM_WORDS    = 750;
   localparam int          CYCLE_LIMIT     = 200000;
   localparam int          DRAIN_CYCLES    = 8;
   localparam logic [3:0]  OP_FIRST_UNUSED = zafa_pkg::OP_DEC16 + 4'd1;
   localparam logic [3:0]  OP_LAST_UNUSED  = 4'hF;

   logic              clock = 1'b0;
   logic              reset;
   logic              start;
   logic              busy;
   zafa_pkg::req_type req_word;
   logic              rsp_valid;
   zafa_pkg::rsp_type rsp_word;
   int                fail_count;
   int                pending_count;
   int                cycle_count = 0;
   int                idle_pct[4] = '{0, 83, 0, 34};

   z80_accumulator_flag_alu_top dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   zafa_alu_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_word      (req_word),
      .rsp_valid     (rsp_valid),
      .rsp_word      (rsp_word),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // clock
   always #6 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic zafa_pkg::req_type make_word(input logic [3:0] op,
                                                   input logic [7:0] a,
                                                   input logic [7:0] f,
                                                   input logic [15:0] wl,
                                                   input logic [15:0] wr);
      zafa_pkg::req_type w;
      w.opcode       = op;
      w.operand_byte = a;
      w.flags_in     = f;
      w.word_left    = wl;
      w.word_right   = wr;
      return w;
   endfunction

   // random word, biased toward boundary operands and pairs
   function automatic zafa_pkg::req_type random_word();
      logic [7:0]        edge_bytes[6] = '{8'h00, 8'hFF, 8'h7F, 8'h80, 8'h99, 8'h9A};
      logic [15:0]       edge_pairs[5] = '{16'h0000, 16'hFFFF, 16'h0FFF, 16'h8000, 16'h7FFF};
      logic [63:0]       raw;
      zafa_pkg::req_type w;
      raw = {$urandom, $urandom};
      w   = raw[$bits(zafa_pkg::req_type)-1:0];
      if ($urandom_range(99) < 90)
         w.opcode = 4'($urandom_range(zafa_pkg::OP_DEC16, zafa_pkg::OP_RLCA));
      else w.opcode = 4'($urandom_range(OP_LAST_UNUSED, OP_FIRST_UNUSED));
      if ($urandom_range(99) < 15) w.operand_byte = edge_bytes[$urandom_range(5)];
      if ($urandom_range(99) < 15) w.word_left = edge_pairs[$urandom_range(4)];
      if ($urandom_range(99) < 15) w.word_right = edge_pairs[$urandom_range(4)];
      return w;
   endfunction

   // present one word from a falling edge until accepted, then optional gap
   task automatic send_word(input zafa_pkg::req_type w, input int gap_pct);
      logic [63:0] raw;
      start    <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy);
      @(negedge clock);
      while ($urandom_range(99) < gap_pct) begin
         raw       = {$urandom, $urandom};
         start    <= 1'b0;
         req_word <= raw[$bits(zafa_pkg::req_type)-1:0];
         @(negedge clock);
      end
   endtask

   // reset, directed corners, random phases, drain and verdict
   initial begin
      int phase;
      int n;
      reset    = 1'b1;
      start    = 1'b0;
      req_word = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // directed corners
      send_word(make_word(zafa_pkg::OP_RLCA,  8'h80, 8'h00, 16'h0000, 16'h0000), 0);
      send_word(make_word(zafa_pkg::OP_RRCA,  8'h01, 8'hFF, 16'hFFFF, 16'hFFFF), 0);
      send_word(make_word(zafa_pkg::OP_RLA,   8'h7F, 8'h01, 16'h1234, 16'h5678), 0);
      send_word(make_word(zafa_pkg::OP_RRA,   8'hFE, 8'hFE, 16'hFFFF, 16'h0000), 0);
      // daa: add side with both corrections, carry in, subtract side
      send_word(make_word(zafa_pkg::OP_DAA,   8'h9A, 8'h00, 16'h0000, 16'h0000), 0);
      send_word(make_word(zafa_pkg::OP_DAA,   8'h00, 8'h01, 16'h0000, 16'h0000), 0);
      send_word(make_word(zafa_pkg::OP_DAA,   8'h0F, 8'h12, 16'h0000, 16'h0000), 0);
      send_word(make_word(zafa_pkg::OP_DAA,   8'hF3, 8'h13, 16'h0000, 16'h0000), 0);
      send_word(make_word(zafa_pkg::OP_DAA,   8'h45, 8'h10, 16'h0000, 16'h0000), 0);
      send_word(make_word(zafa_pkg::OP_DAA,   8'h99, 8'hEC, 16'h0000, 16'h0000), 0);
      send_word(make_word(zafa_pkg::OP_CPL,   8'h55, 8'h00, 16'h0000, 16'h0000), 0);
      send_word(make_word(zafa_pkg::OP_SCF,   8'h00, 8'hD7, 16'h0000, 16'h0000), 0);
      send_word(make_word(zafa_pkg::OP_CCF,   8'h00, 8'h01, 16'h0000, 16'h0000), 0);
      send_word(make_word(zafa_pkg::OP_CCF,   8'hFF, 8'hFE, 16'h0000, 16'h0000), 0);
      // inc/dec overflow, zero and half carry
      send_word(make_word(zafa_pkg::OP_INC8,  8'h7F, 8'h00, 16'h0000, 16'h0000), 0);
      send_word(make_word(zafa_pkg::OP_INC8,  8'hFF, 8'hFF, 16'h0000, 16'h0000), 0);
      send_word(make_word(zafa_pkg::OP_DEC8,  8'h80, 8'h00, 16'h0000, 16'h0000), 0);
      send_word(make_word(zafa_pkg::OP_DEC8,  8'h00, 8'hFF, 16'h0000, 16'h0000), 0);
      send_word(make_word(zafa_pkg::OP_DEC8,  8'h01, 8'h28, 16'h0000, 16'h0000), 0);
      // 16-bit carries and wraps
      send_word(make_word(zafa_pkg::OP_ADD16, 8'h00, 8'hFF, 16'hFFFF, 16'h0001), 0);
      send_word(make_word(zafa_pkg::OP_ADD16, 8'h00, 8'h00, 16'h0FFF, 16'h0001), 0);
      send_word(make_word(zafa_pkg::OP_ADD16, 8'hFF, 8'h00, 16'h8000, 16'h8000), 0);
      send_word(make_word(zafa_pkg::OP_INC16, 8'hAA, 8'h55, 16'hFFFF, 16'h0000), 0);
      send_word(make_word(zafa_pkg::OP_DEC16, 8'h55, 8'hAA, 16'h0000, 16'hFFFF), 0);
      // unused codes pass through
      send_word(make_word(OP_FIRST_UNUSED, 8'h3C, 8'hC3, 16'hBEEF, 16'h1111), 0);
      send_word(make_word(OP_LAST_UNUSED,  8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF), 0);

      // random phases with different sender gap rates
      for (phase = 0; phase < 4; phase++) begin
         for (n = 0; n < RANDOM_WORDS / 4; n++) send_word(random_word(), idle_pct[phase]);
      end
      start    <= 1'b0;
      req_word <= '0;

      // drain outstanding responses, then wait out a further drain margin
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
